// ----- sv/atpll_pkg.sv -----
// Package for the angle tracking PLL: widths, fixed-point shifts and limits,
// and the control word of the shared multiply-accumulate unit.
// No dependencies.
`default_nettype none

package atpll_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int FRAC_BITS      = 32 - ANGLE_BITS;
    localparam int CFG_INDEX_BITS = 2;

    localparam int ACC_W     = 96;
    localparam int PROP_SHIFT = 48;
    localparam int VEL_SHIFT  = 48 - FRAC_BITS;
    localparam int DV_SHIFT   = 24 + FRAC_BITS;
    localparam int DV_W       = ACC_W - DV_SHIFT;
    localparam int DVC_W      = 50;
    localparam int VEL_W      = 48;
    localparam int VSUM_W     = 51;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PROP_GAIN     = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_INTEG_GAIN    = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_PERIOD = CFG_INDEX_BITS'(2);

    localparam logic signed [DV_W-1:0]   DV_POS  = DV_W'(64'h0001_0000_0000_0000);
    localparam logic signed [DV_W-1:0]   DV_NEG  = -DV_POS;
    localparam logic signed [VSUM_W-1:0] VEL_MAX = VSUM_W'(64'h0000_7FFF_FFFF_FFFF);
    localparam logic signed [VSUM_W-1:0] VEL_MIN = -VEL_MAX - VSUM_W'(1);

    typedef struct packed {
        logic load;
        logic add_hi;
    } mac_op_t;

endpackage

`default_nettype wire

// ----- sv/atpll_angle_if.sv -----
// Input channel: one measured angle per transfer.
// Depends on atpll_pkg.
`default_nettype none

interface atpll_angle_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [atpll_pkg::ANGLE_BITS-1:0] measured_angle;

    modport source (output valid, output measured_angle, input ready);
    modport sink   (input valid, input measured_angle, output ready);
endinterface

`default_nettype wire

// ----- sv/atpll_result_if.sv -----
// Result channel: updated angle and velocity estimate per transfer.
// Depends on atpll_pkg.
`default_nettype none

interface atpll_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [atpll_pkg::ANGLE_BITS-1:0] angle_estimate;
    logic signed [31:0]                     velocity_estimate;

    modport source (output valid, output angle_estimate, output velocity_estimate, input ready);
    modport sink   (input valid, input angle_estimate, input velocity_estimate, output ready);
endinterface

`default_nettype wire

// ----- sv/atpll_cfg_if.sv -----
// Configuration write channel: register index and write data.
// Depends on atpll_pkg.
`default_nettype none

interface atpll_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [atpll_pkg::CFG_INDEX_BITS-1:0] index;
    logic [31:0]                         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/atpll_mac.sv -----
// Shared 33x33 signed multiplier with a registered product and a 96-bit
// accumulator that loads a product or adds it shifted up by 32 bits.
// Depends on atpll_pkg.
`default_nettype none

module atpll_mac (
    input  wire logic                         clk,
    input  wire atpll_pkg::mac_op_t           op,
    input  wire logic signed [32:0]           a,
    input  wire logic signed [32:0]           b,
    output logic signed [64:0]                prod,
    output logic signed [atpll_pkg::ACC_W-1:0] acc
);
    import atpll_pkg::*;

    logic signed [65:0]      mul_full;
    logic signed [64:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    assign mul_full = a * b;

    always_comb
    begin
        acc_next = acc_reg;
        if (op.load)
        begin
            acc_next = {{(ACC_W-65){prod_reg[64]}}, prod_reg};
        end
        else if (op.add_hi)
        begin
            acc_next = acc_reg + {prod_reg[ACC_W-33:0], 32'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full[64:0];
        acc_reg  <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

// ----- sv/angle_tracking_pll.sv -----
// Angle tracking PLL with a PI loop filter, built around one shared multiplier.
// An input is taken only in the idle state, so each item is finished before
// the next is accepted; the single 33x33 multiplier works through eight
// partial products per item, one per cycle.
// Reset clears the gains, sample period, angle and velocity to zero.
`default_nettype none

module angle_tracking_pll (
    input  wire logic     clk,
    input  wire logic     rst_n,
    atpll_angle_if.sink   meas,
    atpll_result_if.source result,
    atpll_cfg_if.sink     cfg
);
    import atpll_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    localparam logic [3:0] STEP_KP_ERR  = 4'd0;
    localparam logic [3:0] STEP_KI_ERR  = 4'd1;
    localparam logic [3:0] STEP_KPE_LO  = 4'd2;
    localparam logic [3:0] STEP_KPE_HI  = 4'd3;
    localparam logic [3:0] STEP_KIE_LO  = 4'd4;
    localparam logic [3:0] STEP_KIE_HI  = 4'd5;
    localparam logic [3:0] STEP_VEL_LO  = 4'd6;
    localparam logic [3:0] STEP_VEL_HI  = 4'd7;
    localparam logic [3:0] STEP_VEL_ACC = 4'd8;
    localparam logic [3:0] STEP_DONE    = 4'd9;

    logic                     state_reg, state_next;
    logic [3:0]               step_reg, step_next;
    logic                     out_valid_reg, out_valid_next;

    logic [31:0]              kp_reg, ki_reg, dt_reg;
    logic [31:0]              angle_reg, angle_next;
    logic signed [VEL_W-1:0]  vel_reg, vel_next;

    logic signed [31:0]       err_reg;
    logic signed [63:0]       kpe_reg;
    logic signed [63:0]       kie_reg;
    logic [31:0]              angle_sum_reg;
    logic signed [DVC_W-1:0]  dv_reg;

    logic                     accept;
    logic                     finish;
    mac_op_t                  mac_op;
    logic signed [32:0]       mac_a, mac_b;
    logic signed [64:0]       mac_prod;
    logic signed [ACC_W-1:0]  mac_acc;
    logic signed [DV_W-1:0]   dv_wide;
    logic signed [DVC_W-1:0]  dv_clamped;
    logic signed [VSUM_W-1:0] vel_sum;

    atpll_mac u_mac (
        .clk  (clk),
        .op   (mac_op),
        .a    (mac_a),
        .b    (mac_b),
        .prod (mac_prod),
        .acc  (mac_acc)
    );

    assign accept = meas.valid && meas.ready;
    assign finish = (state_reg == S_RUN) && (step_reg == STEP_DONE)
                    && (!out_valid_reg || result.ready);

    assign meas.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;

    assign result.valid             = out_valid_reg;
    assign result.angle_estimate    = angle_reg[31:FRAC_BITS];
    assign result.velocity_estimate = vel_reg[VEL_W-1:16];

    always_comb
    begin
        mac_a      = '0;
        mac_b      = {1'b0, dt_reg};
        mac_op     = '0;
        case (step_reg)
            STEP_KP_ERR:
            begin
                mac_a = {1'b0, kp_reg};
                mac_b = {err_reg[31], err_reg};
            end
            STEP_KI_ERR:
            begin
                mac_a = {1'b0, ki_reg};
                mac_b = {err_reg[31], err_reg};
            end
            STEP_KPE_LO:
            begin
                mac_a = {1'b0, kpe_reg[31:0]};
            end
            STEP_KPE_HI:
            begin
                mac_a     = {kpe_reg[63], kpe_reg[63:32]};
                mac_op.load = 1'b1;
            end
            STEP_KIE_LO:
            begin
                mac_a       = {1'b0, kie_reg[31:0]};
                mac_op.add_hi = 1'b1;
            end
            STEP_KIE_HI:
            begin
                mac_a       = {kie_reg[63], kie_reg[63:32]};
                mac_op.load = 1'b1;
            end
            STEP_VEL_LO:
            begin
                mac_a       = {1'b0, vel_reg[31:0]};
                mac_op.add_hi = 1'b1;
            end
            STEP_VEL_HI:
            begin
                mac_a       = {{(33-(VEL_W-32)){vel_reg[VEL_W-1]}}, vel_reg[VEL_W-1:32]};
                mac_op.load = 1'b1;
            end
            STEP_VEL_ACC:
            begin
                mac_op.add_hi = 1'b1;
            end
            default:
            begin
                mac_a = '0;
            end
        endcase
    end

    always_comb
    begin
        dv_wide = mac_acc[ACC_W-1:DV_SHIFT];
        if (dv_wide > DV_POS)
        begin
            dv_clamped = DVC_W'(DV_POS);
        end
        else if (dv_wide < DV_NEG)
        begin
            dv_clamped = DVC_W'(DV_NEG);
        end
        else
        begin
            dv_clamped = dv_wide[DVC_W-1:0];
        end
    end

    always_comb
    begin
        vel_sum = {{(VSUM_W-VEL_W){vel_reg[VEL_W-1]}}, vel_reg}
                + {{(VSUM_W-DVC_W){dv_reg[DVC_W-1]}}, dv_reg};
        if (vel_sum > VEL_MAX)
        begin
            vel_next = VEL_MAX[VEL_W-1:0];
        end
        else if (vel_sum < VEL_MIN)
        begin
            vel_next = VEL_MIN[VEL_W-1:0];
        end
        else
        begin
            vel_next = vel_sum[VEL_W-1:0];
        end
        angle_next = angle_sum_reg + mac_acc[VEL_SHIFT+31:VEL_SHIFT];
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                    step_next  = STEP_KP_ERR;
                end
            end
            S_RUN:
            begin
                if (step_reg != STEP_DONE)
                begin
                    step_next = step_reg + 4'd1;
                end
                else if (finish)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_KP_ERR;
            out_valid_reg <= 1'b0;
            kp_reg        <= '0;
            ki_reg        <= '0;
            dt_reg        <= '0;
            angle_reg     <= '0;
            vel_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_PROP_GAIN:     kp_reg <= cfg.data;
                    REG_INTEG_GAIN:    ki_reg <= cfg.data;
                    REG_SAMPLE_PERIOD: dt_reg <= cfg.data;
                    default:           kp_reg <= kp_reg;
                endcase
            end
            if (finish)
            begin
                angle_reg <= angle_next;
                vel_reg   <= vel_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg <= {meas.measured_angle, {FRAC_BITS{1'b0}}} - angle_reg;
        end
        if (step_reg == STEP_KI_ERR)
        begin
            kpe_reg <= mac_prod[63:0];
        end
        if (step_reg == STEP_KPE_LO)
        begin
            kie_reg <= mac_prod[63:0];
        end
        if (step_reg == STEP_KIE_HI)
        begin
            angle_sum_reg <= angle_reg + mac_acc[PROP_SHIFT+31:PROP_SHIFT];
        end
        if (step_reg == STEP_VEL_HI)
        begin
            dv_reg <= dv_clamped;
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !meas.ready)
        else $error("input taken while an item is in progress");

    a_start_at_first_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_RUN) && (step_reg == STEP_KP_ERR))
        else $error("sequencer did not start at the first step");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past((state_reg == S_RUN) && (step_reg == STEP_DONE)))
        else $error("result raised outside the final step");

    a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (step_reg <= STEP_DONE))
        else $error("step counter ran past the final step");

    a_state_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> $stable(angle_reg) && $stable(vel_reg))
        else $error("tracked state changed while the result was stalled");

endmodule

`default_nettype wire
